### src/ngt_pkg.sv
package ngt_pkg;

   localparam int TABLE_DEPTH_DEF = 16;
   localparam int ADDR_BITS_DEF   = 16;

   localparam int IN_ADDR_W  = 16;
   localparam int SEQ_W      = 8;
   localparam int AVG_W      = 16;
   localparam int STATUS_W   = 2;
   localparam int INDEX_W    = 4;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 32;

   localparam logic [AVG_W-1:0] GAP_UNITY   = 16'h0100;
   localparam logic [AVG_W-1:0] GAP_ALPHA   = 16'h0040;
   localparam logic [AVG_W-1:0] GAP_KEEP    = GAP_UNITY - GAP_ALPHA;
   localparam int               UNITY_SHIFT = 8;
   localparam int               PROD_W      = 24;

   typedef enum logic [STATUS_W-1:0] {
      ST_UPDATED = 2'd0,
      ST_ADDED   = 2'd1,
      ST_DROPPED = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_MATCH,
      S_UPDATE,
      S_INSERT
   } ngt_state_type;

   typedef struct packed {
      logic load;
      logic rd_first;
      logic rd_next;
      logic update;
      logic insert;
   } ngt_cmd_type;

   typedef struct packed {
      logic used_zero;
      logic hit;
      logic last;
      logic rsp_free;
   } ngt_status_type;

endpackage

### src/ngt_ram.sv
module ngt_ram
   #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
   )
   (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
   );

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### src/ngt_ctrl.sv
module ngt_ctrl
   import ngt_pkg::*;
   (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   output logic           req_tready,
   input  ngt_status_type status,
   output ngt_cmd_type    cmd
   );

   ngt_state_type state_ff;
   ngt_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               if (status.used_zero) begin
                  state_in = S_INSERT;
               end else begin
                  cmd.rd_first = 1'b1;
                  state_in     = S_MATCH;
               end
            end
         end
         S_MATCH: begin
            if (status.hit) begin
               state_in = S_UPDATE;
            end else if (status.last) begin
               state_in = S_INSERT;
            end else begin
               cmd.rd_next = 1'b1;
            end
         end
         S_UPDATE: begin
            if (status.rsp_free) begin
               cmd.update = 1'b1;
               state_in   = S_IDLE;
            end
         end
         S_INSERT: begin
            if (status.rsp_free) begin
               cmd.insert = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

### src/ngt_datapath.sv
module ngt_datapath
   import ngt_pkg::*;
   #(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
   parameter int ADDR_BITS   = ADDR_BITS_DEF
   )
   (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  ngt_cmd_type           cmd,
   output ngt_status_type        status
   );

   localparam int KEY_W   = (ADDR_BITS < IN_ADDR_W) ? ADDR_BITS : IN_ADDR_W;
   localparam int SLOT_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
   localparam int ENTRY_W = KEY_W + SEQ_W + AVG_W;

   logic [KEY_W-1:0]   addr_ff;
   logic [SEQ_W-1:0]   seq_ff;
   logic [SLOT_W-1:0]  idx_ff;
   logic [CNT_W-1:0]   used_ff;
   logic [CNT_W-1:0]   used_in;

   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   status_type         rsp_status_ff;
   logic [INDEX_W-1:0] rsp_index_ff;
   logic [SEQ_W-1:0]   rsp_gap_ff;
   logic [AVG_W-1:0]   rsp_avg_ff;

   logic               ram_we;
   logic [SLOT_W-1:0]  ram_waddr;
   logic [ENTRY_W-1:0] ram_wdata;
   logic               ram_re;
   logic [SLOT_W-1:0]  ram_raddr;
   logic [ENTRY_W-1:0] ram_rdata;

   logic [KEY_W-1:0]   rd_key;
   logic [SEQ_W-1:0]   rd_prev;
   logic [AVG_W-1:0]   rd_avg;
   logic [SEQ_W-1:0]   upd_gap;
   logic [PROD_W-1:0]  upd_prod;
   logic [AVG_W-1:0]   upd_avg;
   logic               full;
   logic [SLOT_W-1:0]  new_slot;
   logic [SLOT_W+INDEX_W-1:0] idx_wide;
   logic [SLOT_W+INDEX_W-1:0] new_wide;

   assign rd_key  = ram_rdata[ENTRY_W-1 -: KEY_W];
   assign rd_prev = ram_rdata[AVG_W +: SEQ_W];
   assign rd_avg  = ram_rdata[AVG_W-1:0];

   assign upd_gap  = seq_ff - rd_prev;
   assign upd_prod = PROD_W'(rd_avg) * PROD_W'(GAP_KEEP);
   assign upd_avg  = AVG_W'(AVG_W'(upd_gap) * GAP_ALPHA)
                   + AVG_W'(upd_prod >> UNITY_SHIFT);

   assign full     = (used_ff == CNT_W'(TABLE_DEPTH));
   assign new_slot = used_ff[SLOT_W-1:0];
   assign idx_wide = {{INDEX_W{1'b0}}, idx_ff};
   assign new_wide = {{INDEX_W{1'b0}}, new_slot};

   assign status.used_zero = (used_ff == '0);
   assign status.hit       = (rd_key == addr_ff);
   assign status.last      = ((CNT_W'(idx_ff) + CNT_W'(1)) == used_ff);
   assign status.rsp_free  = !rsp_valid_ff || rsp_tready;

   assign ram_re    = cmd.rd_first || cmd.rd_next;
   assign ram_raddr = cmd.rd_next ? SLOT_W'(idx_ff + SLOT_W'(1)) : '0;
   assign ram_we    = cmd.update || (cmd.insert && !full);
   assign ram_waddr = cmd.update ? idx_ff : new_slot;
   assign ram_wdata = cmd.update ? {addr_ff, seq_ff, upd_avg}
                                 : {addr_ff, seq_ff, GAP_UNITY};

   ngt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   always_comb begin
      used_in = used_ff;
      if (cmd.insert && !full) begin
         used_in = used_ff + CNT_W'(1);
      end
      rsp_valid_in = rsp_valid_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.update || cmd.insert) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         addr_ff <= req_tdata[KEY_W-1:0];
         seq_ff  <= req_tdata[IN_ADDR_W +: SEQ_W];
         idx_ff  <= '0;
      end else if (cmd.rd_next) begin
         idx_ff <= SLOT_W'(idx_ff + SLOT_W'(1));
      end
      if (cmd.update) begin
         rsp_status_ff <= ST_UPDATED;
         rsp_index_ff  <= idx_wide[INDEX_W-1:0];
         rsp_gap_ff    <= upd_gap;
         rsp_avg_ff    <= upd_avg;
      end else if (cmd.insert) begin
         if (full) begin
            rsp_status_ff <= ST_DROPPED;
            rsp_index_ff  <= '0;
            rsp_gap_ff    <= '0;
            rsp_avg_ff    <= '0;
         end else begin
            rsp_status_ff <= ST_ADDED;
            rsp_index_ff  <= new_wide[INDEX_W-1:0];
            rsp_gap_ff    <= SEQ_W'(1);
            rsp_avg_ff    <= GAP_UNITY;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_avg_ff, rsp_gap_ff, rsp_index_ff, rsp_status_ff};

endmodule

### src/neighbor_seqno_gap_tracker.sv
// Channel   Direction  Beat contents
// req_      in         sender_addr, seq_number
// rsp_      out        status, entry_index, seq_gap, avg_gap
//
// A packet is handled in order: it is loaded, the table entries are read until the
// sender is found or every filled entry has been read, then the update or insert.
// The table is one memory read one entry per cycle during the search.
// Reset clears the fill count and the result valid; entries are never cleared.
// A new packet is accepted while the previous result still waits in the output
// register; a search only holds at its end if that register is still full.
module neighbor_seqno_gap_tracker
   import ngt_pkg::*;
   #(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
   parameter int ADDR_BITS   = ADDR_BITS_DEF
   )
   (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // sender_addr[15:0], seq_number[23:16]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata   // status[1:0], entry_index[5:2],
                                             // seq_gap[13:6], avg_gap[29:14]
   );

   ngt_cmd_type    cmd;
   ngt_status_type status;

   ngt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   ngt_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .ADDR_BITS   (ADDR_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .status     (status)
   );

endmodule

### tb/ngt_checker.sv
module ngt_checker
   import ngt_pkg::*;
   (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // sender_addr[15:0], seq_number[23:16]
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,   // status[1:0], entry_index[5:2],
                                              // seq_gap[13:6], avg_gap[29:14]
   output int                    fail_count,
   output int                    pending
   );

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      status_type         status;
      logic [INDEX_W-1:0] index;
      logic [SEQ_W-1:0]   gap;
      logic [AVG_W-1:0]   avg;
   } gap_report_type;

   logic [IN_ADDR_W-1:0] known_addr [TABLE_DEPTH_DEF];
   logic [SEQ_W-1:0]     last_seq   [TABLE_DEPTH_DEF];
   logic [AVG_W-1:0]     mean_gap   [TABLE_DEPTH_DEF];
   int                   fill_count;
   gap_report_type       expected_reports [$];

   function automatic gap_report_type track_packet(logic [IN_ADDR_W-1:0] addr,
                                                   logic [SEQ_W-1:0] seq);
      gap_report_type   r;
      int               slot;
      bit               hit;
      logic [SEQ_W-1:0] gap;
      logic [31:0]      next_avg;
      slot = 0;
      hit = 1'b0;
      r.status = ST_UPDATED;
      for (int i = 0; i < fill_count; i++) begin
         if (!hit && known_addr[i] == addr) begin
            slot = i;
            hit = 1'b1;
         end
      end
      if (!hit) begin
         if (fill_count >= TABLE_DEPTH_DEF) begin
            r.status = ST_DROPPED;
            r.index = '0;
            r.gap = '0;
            r.avg = '0;
            return r;
         end
         slot = fill_count;
         fill_count++;
         known_addr[slot] = addr;
         last_seq[slot] = seq - 8'd1;
         mean_gap[slot] = GAP_UNITY;
         r.status = ST_ADDED;
      end
      gap = seq - last_seq[slot];
      next_avg = 32'(gap) * 32'(GAP_ALPHA)
               + ((32'(mean_gap[slot]) * 32'(GAP_KEEP)) >> UNITY_SHIFT);
      if (next_avg > 32'hFFFF) begin
         next_avg = 32'hFFFF;
      end
      mean_gap[slot] = next_avg[AVG_W-1:0];
      last_seq[slot] = seq;
      r.index = slot[INDEX_W-1:0];
      r.gap = gap;
      r.avg = next_avg[AVG_W-1:0];
      return r;
   endfunction

   always @(posedge clock) begin
      gap_report_type want;
      gap_report_type got;
      if (reset) begin
         fill_count = 0;
         expected_reports.delete();
         fail_count <= 0;
         pending <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_reports.push_back(track_packet(req_tdata[15:0], req_tdata[23:16]));
         end
         if (rsp_tvalid && rsp_tready) begin
            got.status = status_type'(rsp_tdata[1:0]);
            got.index = rsp_tdata[5:2];
            got.gap = rsp_tdata[13:6];
            got.avg = rsp_tdata[29:14];
            if (expected_reports.size() == 0) begin
               $display("%0t: unexpected result beat, tdata %h", $time, rsp_tdata);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_reports.pop_front();
               if (got.status !== want.status || got.index !== want.index ||
                   got.gap !== want.gap || got.avg !== want.avg) begin
                  fail_count <= fail_count + 1;
               end
               if (got.status !== want.status) begin
                  $display("%0t: status expected %0d, actual %0d",
                           $time, want.status, got.status);
               end
               if (got.index !== want.index) begin
                  $display("%0t: entry_index expected %0d, actual %0d",
                           $time, want.index, got.index);
               end
               if (got.gap !== want.gap) begin
                  $display("%0t: seq_gap expected %0d, actual %0d",
                           $time, want.gap, got.gap);
               end
               if (got.avg !== want.avg) begin
                  $display("%0t: avg_gap expected %h, actual %h",
                           $time, want.avg, got.avg);
               end
            end
         end
         pending <= expected_reports.size();
      end
   end

endmodule

### tb/tb.sv
module tb
   import ngt_pkg::*;
   ;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_PACKETS = 1830;
   localparam int QUIET_LIMIT    = 2000;
   localparam int HOLD_CYCLES    = 250;
   localparam int DRAIN_CYCLES   = 40;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;   // sender_addr[15:0], seq_number[23:16]
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // status[1:0], entry_index[5:2],
                                       // seq_gap[13:6], avg_gap[29:14]
   int                    fail_count;
   int                    pending;
   int                    quiet_cycles;
   bit                    hold_request;
   int                    steady_left;

   logic [IN_ADDR_W-1:0]  neighbor_addr [TABLE_DEPTH_DEF];
   logic [SEQ_W-1:0]      recent_seq    [TABLE_DEPTH_DEF];

   always #4 clock = ~clock;

   neighbor_seqno_gap_tracker uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   ngt_checker gap_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   function automatic int pick_idle();
      int k;
      if (steady_left > 0) begin
         steady_left--;
         return 0;
      end
      k = $urandom_range(0, 99);
      if (k < 2) begin
         steady_left = 60;
      end
      if (k < 55) begin
         return 0;
      end
      if (k < 93) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   task automatic send_packet(input logic [IN_ADDR_W-1:0] addr, input logic [SEQ_W-1:0] seq);
      int idle;
      idle = pick_idle();
      if (idle > 0) begin
         req_tvalid <= 1'b0;
         repeat (idle) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {seq, addr};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic send_to_slot(input int slot, input logic [SEQ_W-1:0] seq);
      recent_seq[slot] = seq;
      send_packet(neighbor_addr[slot], seq);
   endtask

   function automatic logic [SEQ_W-1:0] next_seq(input int slot);
      int k;
      k = $urandom_range(0, 99);
      if (k < 60) begin
         return recent_seq[slot] + 8'($urandom_range(1, 3));
      end
      if (k < 72) begin
         return recent_seq[slot];
      end
      if (k < 82) begin
         return recent_seq[slot] - 8'd1;
      end
      return 8'($urandom);
   endfunction

   // The receiver stalls on its own; the sender may ask it for one long hold-off.
   initial begin
      int quiet_left;
      int k;
      quiet_left = 0;
      rsp_tready = 1'b0;
      @(negedge clock);
      wait (!reset);
      forever begin
         k = $urandom_range(0, 99);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else if (quiet_left > 0) begin
            quiet_left--;
            rsp_tready <= 1'b1;
            @(negedge clock);
         end else if (k < 3) begin
            quiet_left = 80;
            rsp_tready <= 1'b1;
            @(negedge clock);
         end else if (k < 25) begin
            rsp_tready <= 1'b0;
            repeat (k < 22 ? $urandom_range(1, 3) : $urandom_range(10, 40)) @(negedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(negedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int k;
      int slot;
      int sweep_left;
      logic [IN_ADDR_W-1:0] addr;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      hold_request = 1'b0;
      steady_left = 0;
      sweep_left = 0;
      slot = 0;
      neighbor_addr[0] = 16'h0000;
      neighbor_addr[1] = 16'hFFFF;
      for (int i = 2; i < TABLE_DEPTH_DEF; i++) begin
         neighbor_addr[i] = 16'h0001 << (i - 2);
      end
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Address and seqno extremes, a repeated seqno, full backward steps and a wrap.
      send_to_slot(0, 8'd0);
      send_to_slot(1, 8'd255);
      send_to_slot(0, 8'd0);
      send_to_slot(0, 8'd255);
      send_to_slot(1, 8'd0);
      send_to_slot(0, 8'd254);
      for (int i = 2; i < TABLE_DEPTH_DEF; i++) begin
         send_to_slot(i, 8'(i * 17));
      end
      // The table is full now: an unknown sender is dropped, the last slot still updates.
      send_packet(16'hFFFE, 8'h80);
      send_to_slot(TABLE_DEPTH_DEF - 1, 8'h7F);

      for (int n = 0; n < RANDOM_PACKETS; n++) begin
         if (n == 300) begin
            hold_request = 1'b1;
            steady_left = 80;
         end
         if (n == 900) begin
            req_tvalid <= 1'b0;
            wait (pending == 0);
            @(negedge clock);
         end
         k = $urandom_range(0, 99);
         if (sweep_left > 0) begin
            sweep_left--;
            send_to_slot(slot, recent_seq[slot] - 8'd1);
         end else if (k < 2) begin
            slot = $urandom_range(0, TABLE_DEPTH_DEF - 1);
            sweep_left = 40;
            send_to_slot(slot, recent_seq[slot] - 8'd1);
         end else if (k < 80) begin
            slot = $urandom_range(0, TABLE_DEPTH_DEF - 1);
            send_to_slot(slot, next_seq(slot));
         end else if (k < 90) begin
            addr = neighbor_addr[$urandom_range(0, TABLE_DEPTH_DEF - 1)]
                 ^ (16'h0001 << $urandom_range(0, 15));
            send_packet(addr, 8'($urandom));
         end else begin
            send_packet(16'($urandom), 8'($urandom));
         end
      end

      req_tvalid <= 1'b0;
      wait (pending == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
